>>> design/soas_pkg.sv
// Shared types and constants for the self-organising array store.
// Holds field widths, command and status codes, and the microcode ROM.
// No dependencies.
`default_nettype none

package soas_pkg;

   localparam int CMD_W     = 3;
   localparam int POS_W     = 7;
   localparam int WORD_W    = 32;
   localparam int STAT_W    = 2;
   localparam int FOUND_W   = 6;
   localparam int CNT_OUT_W = 7;
   localparam int CAP_W     = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_READ      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SEARCH_TR = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SEARCH_FR = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
   localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

   localparam int UPC_W = 4;
   typedef logic [UPC_W-1:0] upc_type;

   // microcode addresses
   localparam upc_type A_IDLE     = 4'd0;
   localparam upc_type A_DISPATCH = 4'd1;
   localparam upc_type A_INS_SHFT = 4'd2;
   localparam upc_type A_INS_PUT  = 4'd3;
   localparam upc_type A_REM_SHFT = 4'd4;
   localparam upc_type A_REM_DROP = 4'd5;
   localparam upc_type A_RD_ADDR  = 4'd6;
   localparam upc_type A_RD_TAKE  = 4'd7;
   localparam upc_type A_SCAN     = 4'd8;
   localparam upc_type A_SCAN_END = 4'd9;
   localparam upc_type A_SWP_RD   = 4'd10;
   localparam upc_type A_SWP_HIT  = 4'd11;
   localparam upc_type A_SWP_KEY  = 4'd12;
   localparam upc_type A_FINISH   = 4'd15;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_ACCEPT,
      ACT_INIT,
      ACT_SHIFT_UP,
      ACT_WRITE_KEY,
      ACT_SHIFT_DOWN,
      ACT_DEC_COUNT,
      ACT_READ_POS,
      ACT_CAPTURE,
      ACT_SCAN,
      ACT_READ_PARTNER,
      ACT_WRITE_HIT,
      ACT_WRITE_PARTNER,
      ACT_FINISH
   } act_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_DISPATCH,
      COND_LOOP,
      COND_NO_SWAP,
      COND_RSP_BUSY
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      upc_type  target;
   } ctrl_word_type;

   // Taken jumps go to target or the dispatch step; else upc advances by one.
   // The finish step sits at the top so that falling through wraps to idle.
   function automatic ctrl_word_type ucode_rom(input upc_type addr);
      ctrl_word_type w;
      case (addr)
         A_IDLE:     w = '{ACT_ACCEPT,        COND_NO_REQ,   A_IDLE};
         A_DISPATCH: w = '{ACT_INIT,          COND_DISPATCH, A_FINISH};
         A_INS_SHFT: w = '{ACT_SHIFT_UP,      COND_LOOP,     A_INS_SHFT};
         A_INS_PUT:  w = '{ACT_WRITE_KEY,     COND_ALWAYS,   A_FINISH};
         A_REM_SHFT: w = '{ACT_SHIFT_DOWN,    COND_LOOP,     A_REM_SHFT};
         A_REM_DROP: w = '{ACT_DEC_COUNT,     COND_ALWAYS,   A_FINISH};
         A_RD_ADDR:  w = '{ACT_READ_POS,      COND_NEVER,    A_IDLE};
         A_RD_TAKE:  w = '{ACT_CAPTURE,       COND_ALWAYS,   A_FINISH};
         A_SCAN:     w = '{ACT_SCAN,          COND_LOOP,     A_SCAN};
         A_SCAN_END: w = '{ACT_NONE,          COND_NO_SWAP,  A_FINISH};
         A_SWP_RD:   w = '{ACT_READ_PARTNER,  COND_NEVER,    A_IDLE};
         A_SWP_HIT:  w = '{ACT_WRITE_HIT,     COND_NEVER,    A_IDLE};
         A_SWP_KEY:  w = '{ACT_WRITE_PARTNER, COND_ALWAYS,   A_FINISH};
         A_FINISH:   w = '{ACT_FINISH,        COND_RSP_BUSY, A_FINISH};
         default:    w = '{ACT_NONE,          COND_ALWAYS,   A_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> design/soas_ifs.sv
// Channel interfaces of the self-organising array store: request,
// response and register write. Depends on soas_pkg for field widths.
`default_nettype none

interface soas_req_if;
   import soas_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [POS_W-1:0]         position;
   logic signed [WORD_W-1:0] word;
   modport source (output valid, command, position, word, input ready);
   modport sink   (input valid, command, position, word, output ready);
endinterface

interface soas_rsp_if;
   import soas_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic [FOUND_W-1:0]       found_position;
   logic signed [WORD_W-1:0] read_word;
   logic [CNT_OUT_W-1:0]     element_count;
   modport source (output valid, status, found_position, read_word, element_count,
                   input ready);
   modport sink   (input valid, status, found_position, read_word, element_count,
                   output ready);
endinterface

interface soas_csr_if;
   import soas_pkg::*;
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> design/soas_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module soas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> design/self_organizing_array_store_top.sv
// Self-organising array store: microcoded sequencer over one RAM port pair.
// A search hit may swap entries before the response is given.
// Throughput: one request at a time; shifts and scans walk one entry per cycle
// through the RAM's registered read.
// Reset (synchronous): count cleared, capacity back to 64, entries left as is.
`default_nettype none

module self_organizing_array_store_top #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   soas_req_if.sink   req_chan,
   soas_rsp_if.source rsp_chan,
   soas_csr_if.sink   csr_chan
);
   import soas_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int XW     = (CW > POS_W) ? CW : POS_W;

   // sequencer
   upc_type       upc_ff, upc_in;
   ctrl_word_type cw;
   upc_type       dispatch_pc;
   logic          cond_true;

   // datapath registers
   logic [CAP_W-1:0]      cap_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [XW-1:0]         pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [XW-1:0]         idx_ff, idx_in;
   logic                  live_ff, live_in;
   logic [ADDR_W-1:0]     live_addr_ff, live_addr_in;
   logic [ADDR_W-1:0]     fpos_ff, fpos_in;
   logic [ADDR_W-1:0]     part_ff, part_in;
   logic [STAT_W-1:0]     st_ff, st_in;
   logic [WORD_W-1:0]     rdw_ff, rdw_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [FOUND_W-1:0]   rsp_found_ff, rsp_found_in;
   logic [WORD_W-1:0]    rsp_word_ff, rsp_word_in;
   logic [CNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   // RAM port
   logic                  ram_we, ram_re;
   logic [ADDR_W-1:0]     ram_wa, ram_ra;
   logic [DATA_WIDTH-1:0] ram_wd, ram_q;

   logic [XW-1:0]                cnt_x, cap_x, idx_dec, idx_inc;
   logic                         hit, loop_go, rsp_busy, no_swap;
   logic signed [DATA_WIDTH-1:0] q_signed;

   soas_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_q)
   );

   assign cw       = ucode_rom(upc_ff);
   assign cnt_x    = XW'(count_ff);
   assign cap_x    = XW'(cap_ff);
   assign idx_dec  = idx_ff - 1'b1;
   assign idx_inc  = idx_ff + 1'b1;
   assign q_signed = $signed(ram_q);
   assign hit      = live_ff && (ram_q == key_ff);
   assign rsp_busy = rsp_valid_ff && !rsp_chan.ready;
   assign no_swap  = (st_ff != ST_OK) || (cmd_ff == CMD_SEARCH) ||
                     ((cmd_ff == CMD_SEARCH_TR) && (fpos_ff == '0));

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = (cw.act == ACT_ACCEPT);

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.found_position = rsp_found_ff;
   assign rsp_chan.read_word      = $signed(rsp_word_ff);
   assign rsp_chan.element_count  = rsp_count_ff;

   // datapath driven by the current control word
   always_comb begin
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      live_in      = 1'b0;
      live_addr_in = live_addr_ff;
      fpos_in      = fpos_ff;
      part_in      = part_ff;
      st_in        = st_ff;
      rdw_in       = rdw_ff;
      dispatch_pc  = A_FINISH;
      loop_go      = 1'b0;
      ram_we       = 1'b0;
      ram_wa       = '0;
      ram_wd       = ram_q;
      ram_re       = 1'b0;
      ram_ra       = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_count_in  = rsp_count_ff;

      case (cw.act)
         ACT_ACCEPT: begin
            if (req_chan.valid) begin
               cmd_in = req_chan.command;
               pos_in = XW'(req_chan.position);
               key_in = DATA_WIDTH'($unsigned(req_chan.word));
            end
         end
         ACT_INIT: begin
            st_in   = ST_OK;
            fpos_in = '0;
            rdw_in  = '0;
            idx_in  = '0;
            case (cmd_ff)
               CMD_INSERT: begin
                  idx_in = cnt_x;
                  if (pos_ff <= cnt_x && cnt_x < cap_x && cnt_x < XW'(CAPACITY)) begin
                     dispatch_pc = A_INS_SHFT;
                  end else begin
                     st_in = ST_BAD;
                  end
               end
               CMD_REMOVE: begin
                  idx_in = pos_ff + 1'b1;
                  if (pos_ff < cnt_x) begin
                     dispatch_pc = A_REM_SHFT;
                  end else begin
                     st_in = ST_BAD;
                  end
               end
               CMD_READ: begin
                  if (pos_ff < cnt_x) begin
                     dispatch_pc = A_RD_ADDR;
                  end else begin
                     st_in = ST_BAD;
                  end
               end
               CMD_SEARCH, CMD_SEARCH_TR, CMD_SEARCH_FR: begin
                  dispatch_pc = A_SCAN;
               end
               default: begin
                  st_in = ST_BAD;
               end
            endcase
         end
         ACT_SHIFT_UP: begin
            // write back the entry read last cycle one place up
            ram_we  = live_ff;
            ram_wa  = live_addr_ff + 1'b1;
            loop_go = (idx_ff > pos_ff);
            ram_re  = loop_go;
            ram_ra  = idx_dec[ADDR_W-1:0];
            live_in = loop_go;
            if (loop_go) begin
               idx_in       = idx_dec;
               live_addr_in = idx_dec[ADDR_W-1:0];
            end
         end
         ACT_WRITE_KEY: begin
            ram_we   = 1'b1;
            ram_wa   = pos_ff[ADDR_W-1:0];
            ram_wd   = key_ff;
            count_in = count_ff + 1'b1;
         end
         ACT_SHIFT_DOWN: begin
            ram_we  = live_ff;
            ram_wa  = live_addr_ff - 1'b1;
            loop_go = (idx_ff < cnt_x);
            ram_re  = loop_go;
            ram_ra  = idx_ff[ADDR_W-1:0];
            live_in = loop_go;
            if (loop_go) begin
               idx_in       = idx_inc;
               live_addr_in = idx_ff[ADDR_W-1:0];
            end
         end
         ACT_DEC_COUNT: begin
            count_in = count_ff - 1'b1;
         end
         ACT_READ_POS: begin
            ram_re = 1'b1;
            ram_ra = pos_ff[ADDR_W-1:0];
         end
         ACT_CAPTURE: begin
            rdw_in = WORD_W'(q_signed);
         end
         ACT_SCAN: begin
            loop_go = !hit && (idx_ff < cnt_x);
            ram_re  = loop_go;
            ram_ra  = idx_ff[ADDR_W-1:0];
            live_in = loop_go;
            if (loop_go) begin
               idx_in       = idx_inc;
               live_addr_in = idx_ff[ADDR_W-1:0];
            end
            if (hit) begin
               fpos_in = live_addr_ff;
            end else if (!loop_go) begin
               st_in = ST_MISS;
            end
         end
         ACT_READ_PARTNER: begin
            part_in = (cmd_ff == CMD_SEARCH_FR) ? '0 : fpos_ff - 1'b1;
            ram_re  = 1'b1;
            ram_ra  = part_in;
         end
         ACT_WRITE_HIT: begin
            ram_we = 1'b1;
            ram_wa = fpos_ff;
         end
         ACT_WRITE_PARTNER: begin
            ram_we = 1'b1;
            ram_wa = part_ff;
            ram_wd = key_ff;
            if (cmd_ff == CMD_SEARCH_FR) begin
               fpos_in = '0;
            end
         end
         ACT_FINISH: begin
            if (!rsp_busy) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_found_in  = FOUND_W'(fpos_ff);
               rsp_word_in   = rdw_ff;
               rsp_count_in  = CNT_OUT_W'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // step counter
   always_comb begin
      case (cw.cond)
         COND_NEVER:    cond_true = 1'b0;
         COND_ALWAYS:   cond_true = 1'b1;
         COND_NO_REQ:   cond_true = !req_chan.valid;
         COND_DISPATCH: cond_true = 1'b1;
         COND_LOOP:     cond_true = loop_go;
         COND_NO_SWAP:  cond_true = no_swap;
         COND_RSP_BUSY: cond_true = rsp_busy;
         default:       cond_true = 1'b0;
      endcase
      if (!cond_true) begin
         upc_in = upc_ff + 1'b1;
      end else if (cw.cond == COND_DISPATCH) begin
         upc_in = dispatch_pc;
      end else begin
         upc_in = cw.target;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      live_addr_ff  <= live_addr_in;
      fpos_ff       <= fpos_in;
      part_ff       <= part_in;
      st_ff         <= st_in;
      rdw_ff        <= rdw_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         upc_ff       <= A_IDLE;
         count_ff     <= '0;
         live_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
      end else begin
         upc_ff       <= upc_in;
         count_ff     <= count_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            cap_ff <= csr_chan.data;
         end
      end
   end

endmodule

`default_nettype wire
